>>> src/bmre_pkg.sv
// ----------------------------------------------------------------------------
// bmre_pkg: shared types and constants for the morphology row engine
// Row and buffer sizes, configuration register indexes and the structs
// that pass the working configuration and the line buffer control.
// ----------------------------------------------------------------------------
`default_nettype none
package bmre_pkg;

	localparam int ROW_W      = 64;
	localparam int ELEM_N     = 8;
	localparam int CNT_W      = 4;
	localparam int IDX_W      = 3;
	localparam int WIDTH_W    = 7;
	localparam int CFG_ADDR_W = 3;

	localparam logic [CFG_ADDR_W-1:0] REG_MODE        = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_ELEM_HEIGHT = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_ELEM_WIDTH  = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_ELEM_MASK   = 3'd4;

	localparam logic MODE_DILATE = 1'b1;

	typedef logic [ROW_W-1:0] row_t;
	typedef logic [ELEM_N-1:0][ROW_W-1:0] row_arr_t;

	// working configuration, already clamped
	typedef struct packed {
		logic             mode;
		row_t             wmask;
		logic [CNT_W-1:0] elem_h;
		logic [CNT_W-1:0] elem_w;
		logic [CNT_W-1:0] need;
		logic [ROW_W-1:0] emask;
	} cfg_t;

	// line buffer to output register
	typedef struct packed {
		logic emit;
		logic last;
	} lb_ctl_t;

endpackage
`default_nettype wire

>>> src/bmre_window_eval.sv
// ----------------------------------------------------------------------------
// bmre_window_eval: erosion / dilation of the oldest held row
// All element taps over the held rows are evaluated in parallel and
// or-reduced into one hit/miss vector with one bit per column.
// ----------------------------------------------------------------------------
`default_nettype none
module bmre_window_eval (
	input  var bmre_pkg::row_arr_t        rows,
	input  var logic [bmre_pkg::CNT_W-1:0] count,
	input  var bmre_pkg::cfg_t            cfg,
	output var bmre_pkg::row_t            result
);
	import bmre_pkg::*;

	row_t acc;
	row_t cur;

	always_comb begin
		row_t row;
		acc = '0;
		for (int a = 0; a < ELEM_N; a++) begin
			row = rows[a] & cfg.wmask;
			for (int b = 0; b < ELEM_N; b++) begin
				// taps below the held rows or outside the element are skipped
				if ((CNT_W'(a) < cfg.elem_h) && (CNT_W'(a) < count) &&
				    (CNT_W'(b) < cfg.elem_w) && cfg.emask[ELEM_N*a+b]) begin
					if (cfg.mode == MODE_DILATE) begin
						acc = acc | (row >> b);
					end else begin
						acc = acc | (~(row >> b) & (cfg.wmask >> b));
					end
				end
			end
		end
	end

	assign cur = rows[0] & cfg.wmask;

	always_comb begin
		if (cfg.mode == MODE_DILATE) begin
			result = (cur | acc) & cfg.wmask;
		end else begin
			result = cur & ~acc & cfg.wmask;
		end
	end

endmodule
`default_nettype wire

>>> src/bmre_line_buffer.sv
// ----------------------------------------------------------------------------
// bmre_line_buffer: row store and release control
// Holds up to eight rows oldest first, decides when the oldest row is
// released and when a new row can be taken in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module bmre_line_buffer (
	input  var logic                       clk,
	input  var logic                       arst_n,
	input  var bmre_pkg::cfg_t             cfg,
	input  var logic                       push,
	input  var bmre_pkg::row_t             push_row,
	input  var logic                       push_last,
	input  var logic                       out_free,
	output var logic                       ready,
	output var bmre_pkg::lb_ctl_t          ctl,
	output var bmre_pkg::row_arr_t         rows,
	output var logic [bmre_pkg::CNT_W-1:0] count
);
	import bmre_pkg::*;

	row_arr_t         rows_q;
	row_arr_t         rows_shift;
	logic [CNT_W-1:0] count_q;
	logic             drain_q;
	logic             flush_q;
	logic             emit_want;
	logic             emit;
	logic             final_one;
	logic [CNT_W-1:0] wr_pos;

	// rows are released only while draining after a push
	assign emit_want = drain_q && (flush_q ? (count_q != '0) : (count_q >= cfg.need));
	assign emit      = emit_want && out_free;
	assign final_one = flush_q ? (count_q == CNT_W'(1)) : (count_q == cfg.need);
	assign ready     = !emit_want || (emit && final_one);
	assign wr_pos    = emit ? (count_q - CNT_W'(1)) : count_q;

	// store moved down by one row, top slot refilled with zero
	assign rows_shift = {row_t'('0), rows_q[ELEM_N-1:1]};

	assign ctl.emit = emit;
	assign ctl.last = flush_q && (count_q == CNT_W'(1));
	assign rows     = rows_q;
	assign count    = count_q;

	always_ff @(posedge clk) begin
		for (int i = 0; i < ELEM_N; i++) begin
			if (push && (wr_pos[IDX_W-1:0] == IDX_W'(i))) begin
				rows_q[i] <= push_row;
			end else if (emit) begin
				rows_q[i] <= rows_shift[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			drain_q <= 1'b0;
			flush_q <= 1'b0;
		end else begin
			count_q <= count_q - CNT_W'(emit) + CNT_W'(push);
			if (push) begin
				drain_q <= 1'b1;
				flush_q <= push_last;
			end else begin
				if (!emit_want) begin
					drain_q <= 1'b0;
				end
				if (emit && ctl.last) begin
					flush_q <= 1'b0;
				end
			end
		end
	end

endmodule
`default_nettype wire

>>> src/binary_morphology_row_engine_unit.sv
// ----------------------------------------------------------------------------
// binary_morphology_row_engine_unit: binary erosion / dilation by rows
// Configuration registers, line buffer, window evaluation and the
// registered result word.
// ----------------------------------------------------------------------------
// One image row enters per input word; a row leaves once the element height
// of rows starting at it has arrived, so in steady state the block takes and
// gives one word per cycle while m_tready is high. The release logic moves one
// row per cycle from the line buffer head into the result register while it
// is free: a row that frees k rows (after the element height was lowered, or
// a frame_end row that flushes every held row) holds s_tready low until the
// last has moved. The last row of a frame is flagged on m_tlast. Window
// positions below the frame or right of image_width are skipped. Configuration
// must be written by the user only while no result is pending, also in the
// middle of a frame; the block does not enforce this. Held rows are evaluated
// with the registers in force when they leave. No clearing pass after reset.
`default_nettype none
module binary_morphology_row_engine_unit (
	input  var logic                            clk,
	input  var logic                            arst_n,
	input  var logic                            cfg_we,
	input  var logic [bmre_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  var logic [bmre_pkg::ROW_W-1:0]      cfg_wdata,
	input  var logic                            s_tvalid,
	output var logic                            s_tready,
	input  var logic [bmre_pkg::ROW_W-1:0]      s_tdata,  // [63:0] row_pixels
	input  var logic                            s_tlast,  // frame_end
	output var logic                            m_tvalid,
	input  var logic                            m_tready,
	output var logic [bmre_pkg::ROW_W-1:0]      m_tdata,  // [63:0] result_pixels
	output var logic                            m_tlast   // result_last
);
	import bmre_pkg::*;

	logic               mode_q;
	logic [WIDTH_W-1:0] image_width_q;
	logic [CNT_W-1:0]   elem_height_q;
	logic [CNT_W-1:0]   elem_width_q;
	logic [ROW_W-1:0]   elem_mask_q;

	cfg_t               cfg;
	logic [WIDTH_W-1:0] width_c;
	logic               push;
	logic               out_free;
	lb_ctl_t            ctl;
	row_arr_t           rows;
	logic [CNT_W-1:0]   count;
	row_t               result;

	logic               m_tvalid_q;
	row_t               m_tdata_q;
	logic               m_tlast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= 1'b0;
			image_width_q <= WIDTH_W'(ROW_W);
			elem_height_q <= CNT_W'(2);
			elem_width_q  <= CNT_W'(2);
			elem_mask_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_MODE:        mode_q        <= cfg_wdata[0];
				REG_IMAGE_WIDTH: image_width_q <= cfg_wdata[WIDTH_W-1:0];
				REG_ELEM_HEIGHT: elem_height_q <= cfg_wdata[CNT_W-1:0];
				REG_ELEM_WIDTH:  elem_width_q  <= cfg_wdata[CNT_W-1:0];
				REG_ELEM_MASK:   elem_mask_q   <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// clamp sizes and build the column mask
	assign width_c = (image_width_q > WIDTH_W'(ROW_W)) ? WIDTH_W'(ROW_W) : image_width_q;

	always_comb begin
		cfg.mode   = mode_q;
		cfg.emask  = elem_mask_q;
		cfg.elem_h = (elem_height_q > CNT_W'(ELEM_N)) ? CNT_W'(ELEM_N) : elem_height_q;
		cfg.elem_w = (elem_width_q > CNT_W'(ELEM_N)) ? CNT_W'(ELEM_N) : elem_width_q;
		cfg.need   = (cfg.elem_h == '0) ? CNT_W'(1) : cfg.elem_h;
		if (width_c >= WIDTH_W'(ROW_W)) begin
			cfg.wmask = '1;
		end else begin
			cfg.wmask = (ROW_W'(1) << width_c) - ROW_W'(1);
		end
	end

	assign out_free = !m_tvalid_q || m_tready;
	assign push     = s_tvalid && s_tready;

	bmre_line_buffer u_line_buffer (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.push      (push),
		.push_row  (s_tdata & cfg.wmask),
		.push_last (s_tlast),
		.out_free  (out_free),
		.ready     (s_tready),
		.ctl       (ctl),
		.rows      (rows),
		.count     (count)
	);

	bmre_window_eval u_window_eval (
		.rows   (rows),
		.count  (count),
		.cfg    (cfg),
		.result (result)
	);

	// result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (ctl.emit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			m_tdata_q <= result;
			m_tlast_q <= ctl.last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

endmodule
`default_nettype wire

>>> sim/binary_morphology_row_engine_unit_tb.sv
// ----------------------------------------------------------------------------
// binary_morphology_row_engine_unit_tb: self-checking bench for the row engine
// Streams image rows through the engine under many register settings and
// compares every output row and its frame flag against a behavioral model
// of the erosion / dilation line buffer kept in a small scoreboard class.
// ----------------------------------------------------------------------------
`default_nettype none
module binary_morphology_row_engine_unit_tb;
	import bmre_pkg::*;

	localparam int STALL_LIMIT = 3000;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 16;
	localparam int ROW_TARGET = 450;

	// model of the engine plus the queue of rows still owed by it
	class row_scoreboard;
		logic             mode = 1'b0;
		logic [6:0]       img_w = 7'd64;
		logic [3:0]       elem_h = 4'd2;
		logic [3:0]       elem_w = 4'd2;
		row_t             elem_mask = '0;
		row_t             held [ELEM_N];
		int unsigned      held_n = 0;
		row_t             due_pixels [$];
		logic             due_last [$];
		int               mismatches = 0;
		int               checked = 0;

		function void set_reg(logic [CFG_ADDR_W-1:0] idx, row_t val);
			case (idx)
				REG_MODE:        mode = val[0];
				REG_IMAGE_WIDTH: img_w = val[WIDTH_W-1:0];
				REG_ELEM_HEIGHT: elem_h = val[CNT_W-1:0];
				REG_ELEM_WIDTH:  elem_w = val[CNT_W-1:0];
				REG_ELEM_MASK:   elem_mask = val;
				default: ;
			endcase
		endfunction

		function int unsigned clamp_elem(logic [3:0] v);
			return (v > ELEM_N) ? ELEM_N : v;
		endfunction

		function row_t width_mask();
			int w;
			w = (img_w > ROW_W) ? ROW_W : img_w;
			if (w >= ROW_W)
				return '1;
			return (64'd1 << w) - 64'd1;
		endfunction

		// erode or dilate the head row using the rows held below it
		function row_t morph_row(row_t wm);
			int unsigned eh, ew, a, b;
			row_t cur, acc, line;
			eh = clamp_elem(elem_h);
			ew = clamp_elem(elem_w);
			cur = held[0] & wm;
			acc = '0;
			for (a = 0; a < eh; a++) begin
				if (a >= held_n)
					break;
				line = held[a] & wm;
				for (b = 0; b < ew; b++) begin
					if (!elem_mask[8*a+b])
						continue;
					if (mode == MODE_DILATE)
						acc |= line >> b;
					else
						acc |= ~(line >> b) & (wm >> b);
				end
			end
			if (mode == MODE_DILATE)
				return (cur | acc) & wm;
			return cur & ~acc & wm;
		endfunction

		function void drop_head();
			if (held_n == 0)
				return;
			for (int i = 0; i < ELEM_N - 1; i++)
				held[i] = held[i+1];
			held_n--;
		endfunction

		function void take_row(row_t px, logic frame_end);
			row_t wm;
			int unsigned need, n;
			wm = width_mask();
			need = clamp_elem(elem_h);
			n = 0;
			if (need == 0)
				need = 1;
			if (held_n >= ELEM_N)
				drop_head();
			held[held_n] = px & wm;
			held_n++;
			if (frame_end) begin
				while (held_n > 0 && n < ELEM_N) begin
					due_pixels.push_back(morph_row(wm));
					due_last.push_back(held_n == 1);
					n++;
					drop_head();
				end
				held_n = 0;
			end else begin
				while (held_n >= need && n < ELEM_N) begin
					due_pixels.push_back(morph_row(wm));
					due_last.push_back(1'b0);
					n++;
					drop_head();
				end
			end
		endfunction

		function void check_row(row_t px, logic last);
			row_t want_px;
			logic want_last;
			if (due_pixels.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word: pixels %h last %b", px, last);
				return;
			end
			want_px = due_pixels.pop_front();
			want_last = due_last.pop_front();
			checked++;
			if (px !== want_px || last !== want_last) begin
				mismatches++;
				if (mismatches <= 10)
					$display("row %0d: got pixels %h last %b, expected pixels %h last %b",
						checked, px, last, want_px, want_last);
			end
		endfunction

		function int pending();
			return due_pixels.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_ADDR_W-1:0] cfg_addr;
	row_t                  cfg_wdata;
	logic                  s_tvalid;
	logic                  s_tready;
	row_t                  s_tdata;  // [63:0] row_pixels
	logic                  s_tlast;  // frame_end
	logic                  m_tvalid;
	logic                  m_tready;
	row_t                  m_tdata;  // [63:0] result_pixels
	logic                  m_tlast;  // result_last

	row_scoreboard sb;
	int rows_sent;
	int frames_done;
	int settings_done;
	int quiet;
	bit pressure_go;
	bit pressure_served;

	binary_morphology_row_engine_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (s_tvalid && s_tready)
			sb.take_row(s_tdata, s_tlast);
		if (m_tvalid && m_tready)
			sb.check_row(m_tdata, m_tlast);
	end

	function automatic int pick_gap();
		int r;
		r = $urandom % 20;
		if (r < 8)
			return 0;
		if (r < 18)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic row_t rand_row();
		case ($urandom % 6)
			0: return '1;
			1: return {$urandom, $urandom};
			2: return {$urandom, $urandom} & {$urandom, $urandom};
			3: return {$urandom, $urandom} | {$urandom, $urandom};
			4: return ~(64'd1 << ($urandom % 64));
			default: return 64'd1 << ($urandom % 64);
		endcase
	endfunction

	task automatic send_row(row_t px, logic frame_end, int gap);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= px;
		s_tlast <= frame_end;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		rows_sent++;
		if (frame_end)
			frames_done++;
	endtask

	// drop valid and wait until every owed row is out and the engine is quiet
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_cfg(logic [CFG_ADDR_W-1:0] idx, row_t val);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		sb.set_reg(idx, val);
	endtask

	task automatic set_config(logic m, logic [6:0] w, logic [3:0] eh, logic [3:0] ew,
		row_t mask);
		settle();
		write_cfg(REG_MODE, row_t'(m));
		write_cfg(REG_IMAGE_WIDTH, row_t'(w));
		write_cfg(REG_ELEM_HEIGHT, row_t'(eh));
		write_cfg(REG_ELEM_WIDTH, row_t'(ew));
		write_cfg(REG_ELEM_MASK, mask);
		cfg_we <= 1'b0;
		@(posedge clk);
		settings_done++;
	endtask

	function automatic logic [3:0] rand_elem();
		case ($urandom % 10)
			0: return 4'd0;
			1: return 4'($urandom_range(9, 15));
			2: return 4'd8;
			3: return 4'd1;
			default: return 4'($urandom_range(1, 8));
		endcase
	endfunction

	task automatic random_config();
		logic [6:0] w;
		row_t mask;
		case ($urandom % 20)
			0: w = 7'd0;
			1, 2: w = 7'd64;
			3: w = 7'($urandom_range(65, 127));
			4: w = 7'd1;
			default: w = 7'($urandom_range(1, 64));
		endcase
		case ($urandom % 4)
			0: mask = {$urandom, $urandom};
			1: mask = {$urandom, $urandom} | {$urandom, $urandom};
			2: mask = {$urandom, $urandom} & {$urandom, $urandom};
			default: mask = 64'd1 << ($urandom % 64);
		endcase
		set_config(1'($urandom % 2), w, rand_elem(), rand_elem(), mask);
	endtask

	// receiver: random stalls, plus one long hold-off while rows keep coming
	initial begin
		int gap;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (pressure_go && !pressure_served) begin
				pressure_served = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				gap = pick_gap();
				if (gap > 0) begin
					m_tready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				m_tready <= 1'b1;
				repeat ($urandom_range(1, ($urandom % 5 == 0) ? 60 : 6)) @(posedge clk);
			end
		end
	end

	initial begin
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("no word moved for %0d cycles, %0d rows still owed", quiet, sb.pending());
		$display("Verification failed");
		$finish;
	end

	initial begin
		int len, brk, gap_max;
		row_t px;
		sb = new;
		rows_sent = 0;
		frames_done = 0;
		settings_done = 0;
		pressure_go = 1'b0;
		pressure_served = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = REG_MODE;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// register values after reset: empty element passes rows through
		send_row('1, 1'b0, pick_gap());
		send_row('0, 1'b0, pick_gap());
		send_row(64'hA5A5_5A5A_F00F_0FF0, 1'b1, pick_gap());

		// 2x2 erosion over a full frame with one hole
		set_config(1'b0, 7'd64, 4'd2, 4'd2, 64'h0303);
		send_row('1, 1'b0, pick_gap());
		send_row('1, 1'b0, pick_gap());
		send_row(~(64'd1 << 20), 1'b0, pick_gap());
		send_row('1, 1'b1, pick_gap());

		// narrowest image, largest full element, rows held until flush
		set_config(1'b1, 7'd1, 4'd8, 4'd8, '1);
		send_row(64'd1, 1'b0, pick_gap());
		send_row('0, 1'b0, pick_gap());
		send_row('1, 1'b1, pick_gap());

		// zero width, element sizes beyond range
		set_config(1'b1, 7'd0, 4'd15, 4'd12, 64'h8000_0000_0000_0001);
		send_row(64'hFFFF, 1'b0, pick_gap());
		send_row('1, 1'b1, pick_gap());

		// width beyond range, zero-sized element
		set_config(1'b0, 7'd100, 4'd0, 4'd0, '1);
		send_row({$urandom, $urandom}, 1'b0, pick_gap());
		send_row({$urandom, $urandom}, 1'b1, pick_gap());

		// lowering the height mid-frame makes the next row release all held rows
		set_config(1'b1, 7'd64, 4'd5, 4'd3, 64'h0000_0007_0000_0502);
		for (int i = 0; i < 4; i++)
			send_row(64'd1 << ($urandom % 64), 1'b0, pick_gap());
		set_config(1'b1, 7'd64, 4'd1, 4'd3, 64'h0000_0007_0000_0502);
		send_row(64'h8000_0000_0000_0000, 1'b0, pick_gap());
		send_row({$urandom, $urandom}, 1'b1, pick_gap());

		// single-row frames
		set_config(1'b0, 7'd37, 4'd3, 4'd4, {$urandom, $urandom});
		send_row('1, 1'b1, pick_gap());
		send_row({$urandom, $urandom}, 1'b1, pick_gap());

		while (rows_sent < ROW_TARGET) begin
			random_config();
			for (int f = $urandom_range(1, 4); f > 0; f--) begin
				len = ($urandom % 3 == 0) ? $urandom_range(1, 12) : $urandom_range(1, 5);
				gap_max = ($urandom % 4 == 0) ? 0 : 1;
				if (!pressure_served && !pressure_go && rows_sent >= 200) begin
					pressure_go = 1'b1;
					len = 24;
					gap_max = 0;
				end
				brk = ($urandom % 6 == 0 && len > 1) ? $urandom_range(1, len - 1) : 0;
				for (int i = 0; i < len; i++) begin
					// frame left open while the registers change under held rows
					if (brk != 0 && i == brk)
						random_config();
					px = rand_row();
					send_row(px, i == len - 1, gap_max ? pick_gap() : 0);
				end
			end
		end

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("covered %0d frames: %0d rows in, %0d rows out, %0d register settings",
			frames_done, rows_sent, sb.checked, settings_done);
		$display("mismatches %0d, rows still owed %0d", sb.mismatches, sb.pending());
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
`default_nettype wire

>>> filelist.f
src/bmre_pkg.sv
src/bmre_window_eval.sv
src/bmre_line_buffer.sv
src/binary_morphology_row_engine_unit.sv
sim/binary_morphology_row_engine_unit_tb.sv
